>>> rtl/mcm_pkg.sv
// Shared types and constants for the MIDI CC trigger mapper.
package mcm_pkg;

    localparam int SLOT_REGS     = 8;
    localparam int TRIGGER_SLOTS = 8;
    localparam int SLOT_W        = $clog2(SLOT_REGS);

    localparam logic [7:0] CC_FIRST = 8'hB0;
    localparam logic [7:0] CC_LAST  = 8'hBF;

    localparam logic [6:0] CTRL_RANGE_LAST = 7'd67;
    localparam logic [6:0] CTRL_EXTRA      = 7'd122;

    localparam int SCALE_DIV = 127;

    localparam int CFG_W   = 26;
    localparam int VALUE_W = 16;

    typedef struct packed {
        logic signed [VALUE_W-1:0] span;
        logic                      up_only;
        logic                      toggle;
        logic                      enable;
        logic [6:0]                ctrl;
    } slot_cfg_t;

    typedef struct packed {
        logic                      hit;
        logic [SLOT_W-1:0]         index;
        logic signed [VALUE_W-1:0] span;
        logic                      toggle;
        logic                      up_only;
    } match_t;

endpackage

>>> rtl/mcm_slot_table.sv
// Trigger slot registers and the lowest-slot-first controller match.
module mcm_slot_table
    import mcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SLOT_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic [6:0]        ctrl,
    output match_t            match
);

    slot_cfg_t slot_reg [SLOT_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_REGS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            slot_reg[cfg_index] <= slot_cfg_t'(cfg_data);
        end
    end

    always_comb
    begin
        match = '0;
        for (int i = TRIGGER_SLOTS - 1; i >= 0; i--)
        begin
            if (slot_reg[i].enable && (slot_reg[i].ctrl == ctrl))
            begin
                match.hit     = 1'b1;
                match.index   = SLOT_W'(i);
                match.span    = slot_reg[i].span;
                match.toggle  = slot_reg[i].toggle;
                match.up_only = slot_reg[i].up_only;
            end
        end
    end

endmodule

>>> rtl/mcm_scaler.sv
// Scales a data byte by the slot span and divides by 127, truncating toward zero.
module mcm_scaler
    import mcm_pkg::*;
(
    input  logic [6:0]                data,
    input  logic signed [VALUE_W-1:0] span,
    output logic signed [VALUE_W-1:0] value
);

    logic signed [23:0] prod;
    logic               neg;
    logic [23:0]        mag;
    logic [15:0]        a1;
    logic [15:0]        s1;
    logic [8:0]         a2;
    logic [8:0]         s2;
    logic [1:0]         q3;
    logic [15:0]        quo;

    // m = 127*(a1 + a2) + s2, with s2 below 3*127 + 1
    always_comb
    begin
        prod = $signed({{17{1'b0}}, data}) * $signed({{8{span[VALUE_W-1]}}, span});
        neg  = prod[23];
        mag  = neg ? 24'(-prod) : prod;
        a1   = 16'(mag[22:7]);
        s1   = a1 + 16'(mag[6:0]);
        a2   = 9'(s1[15:7]);
        s2   = a2 + 9'(s1[6:0]);
        if (s2 >= 9'(3 * SCALE_DIV))
            q3 = 2'd3;
        else if (s2 >= 9'(2 * SCALE_DIV))
            q3 = 2'd2;
        else if (s2 >= 9'(SCALE_DIV))
            q3 = 2'd1;
        else
            q3 = 2'd0;
        quo   = a1 + 16'(a2) + 16'(q3);
        value = neg ? $signed(~quo + 16'd1) : $signed(quo);
    end

endmodule

>>> rtl/midi_cc_trigger_mapper.sv
// Top level of the MIDI control change trigger mapper.
//
// Input channel: status_byte, controller_number, controller_value, one MIDI
// word per accepted handshake (in_valid high, in_stall low). Output channel:
// slot_index and trigger_value, delivered when out_valid is high and
// out_stall is low. Configuration: cfg_index selects a trigger slot, cfg_data
// carries its 26-bit packing; cfg_ready is always high.
//
// An accepted word waits in the input register until the result register is
// free, then advances; if it fires, out_valid rises with its result.
// Throughput: one word per cycle while no held result is stalled; slot
// match, scaling and the per-slot cache update all resolve between the input
// register and the result register. Words that do not fire leave no result.
//
// Reset clears slot registers, cached values, toggle bits and both valid
// flags. When the receiver stalls with a result held, the input register
// holds too and in_stall rises while a word waits in it.
module midi_cc_trigger_mapper
    import mcm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                status_byte,
    input  logic [6:0]                controller_number,
    input  logic [6:0]                controller_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                slot_index,
    output logic signed [VALUE_W-1:0] trigger_value,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [SLOT_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    logic                      in_valid_reg;
    logic [7:0]                status_reg;
    logic [6:0]                ctrl_reg;
    logic [6:0]                data_reg;

    logic                      out_valid_reg;
    logic [2:0]                slot_reg;
    logic signed [VALUE_W-1:0] value_reg;

    logic signed [VALUE_W-1:0] last_value_reg [SLOT_REGS];
    logic [SLOT_REGS-1:0]      toggle_reg;

    match_t                    match;
    logic signed [VALUE_W-1:0] scaled;
    logic                      out_free;
    logic                      advance;
    logic                      in_accept;
    logic                      hit;
    logic                      changed;
    logic                      positive;
    logic                      toggle_next;
    logic                      emit;
    logic signed [VALUE_W-1:0] emit_value;

    assign cfg_ready = 1'b1;

    mcm_slot_table u_slot_table
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl_reg),
        .match     (match)
    );

    mcm_scaler u_scaler
    (
        .data  (data_reg),
        .span  (match.span),
        .value (scaled)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        hit = match.hit
            && (status_reg >= CC_FIRST) && (status_reg <= CC_LAST)
            && ((ctrl_reg <= CTRL_RANGE_LAST) || (ctrl_reg == CTRL_EXTRA));
        changed     = hit && (scaled != last_value_reg[match.index]);
        positive    = !scaled[VALUE_W-1] && (scaled != '0);
        toggle_next = !toggle_reg[match.index];
        if (match.toggle)
        begin
            emit       = changed && positive;
            emit_value = VALUE_W'(toggle_next);
        end
        else if (match.up_only)
        begin
            emit       = changed && (scaled != '0);
            emit_value = scaled;
        end
        else
        begin
            emit       = changed;
            emit_value = scaled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            status_reg <= status_byte;
            ctrl_reg   <= controller_number;
            data_reg   <= controller_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_REGS; i++)
            begin
                last_value_reg[i] <= '0;
            end
            toggle_reg <= '0;
        end
        else if (advance && changed)
        begin
            last_value_reg[match.index] <= scaled;
            if (match.toggle && positive)
            begin
                toggle_reg[match.index] <= toggle_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            slot_reg  <= 3'(match.index);
            value_reg <= emit_value;
        end
    end

    assign out_valid     = out_valid_reg;
    assign slot_index    = slot_reg;
    assign trigger_value = value_reg;

endmodule

>>> rtl/mcm_checker.sv
// Port-level assertions for the MIDI CC trigger mapper, bound to the top level.
module mcm_checker
    import mcm_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [2:0]                slot_index,
    input logic signed [VALUE_W-1:0] trigger_value,
    input logic                      cfg_ready
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(slot_index) && $stable(trigger_value))
        else $error("stalled result word changed");

    // input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("in_stall without a stalled result");

    // a fresh result comes from an earlier accepted input word
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a matching input word");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind midi_cc_trigger_mapper mcm_checker u_mcm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .slot_index    (slot_index),
    .trigger_value (trigger_value),
    .cfg_ready     (cfg_ready)
);

>>> test/tb_midi_cc_trigger_mapper.sv
// Self-checking testbench for the MIDI CC trigger mapper under four pacing phases.
module tb_midi_cc_trigger_mapper;
    timeunit 1ns;
    timeprecision 1ps;
    import mcm_pkg::*;

    localparam int WORDS_PER_PHASE = 325;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct packed {
        logic [SLOT_W-1:0]         slot;
        logic signed [VALUE_W-1:0] value;
    } trigger_t;

    class trigger_scoreboard;
        slot_cfg_t                 slot_cfg [SLOT_REGS];
        logic signed [VALUE_W-1:0] cached_value [SLOT_REGS];
        logic                      toggle_state [SLOT_REGS];
        trigger_t                  expected_triggers [$];
        int                        mismatches;
        int                        triggers_seen;

        function new();
            for (int i = 0; i < SLOT_REGS; i++)
            begin
                slot_cfg[i]     = '0;
                cached_value[i] = '0;
                toggle_state[i] = 1'b0;
            end
            mismatches    = 0;
            triggers_seen = 0;
        endfunction

        function void write_slot(int idx, logic [CFG_W-1:0] data);
            slot_cfg[idx] = slot_cfg_t'(data);
        endfunction

        function void note_word(logic [7:0] status, logic [6:0] ctrl, logic [6:0] data);
            int       hit;
            int       span;
            int       scaled;
            trigger_t trig;
            hit = -1;
            if (status < CC_FIRST || status > CC_LAST)
                return;
            if (!(ctrl <= CTRL_RANGE_LAST || ctrl == CTRL_EXTRA))
                return;
            for (int i = 0; i < TRIGGER_SLOTS; i++)
            begin
                if (hit < 0 && slot_cfg[i].enable && slot_cfg[i].ctrl == ctrl)
                    hit = i;
            end
            if (hit < 0)
                return;
            span   = $signed(slot_cfg[hit].span);
            scaled = (int'(data) * span) / SCALE_DIV;
            if (scaled == int'(cached_value[hit]))
                return;
            cached_value[hit] = scaled[VALUE_W-1:0];
            if (slot_cfg[hit].toggle)
            begin
                if (scaled <= 0)
                    return;
                toggle_state[hit] = ~toggle_state[hit];
                scaled = toggle_state[hit];
            end
            else if (slot_cfg[hit].up_only && scaled == 0)
                return;
            trig.slot  = hit[SLOT_W-1:0];
            trig.value = scaled[VALUE_W-1:0];
            expected_triggers.push_back(trig);
        endfunction

        function void check_result(logic [SLOT_W-1:0] slot, logic signed [VALUE_W-1:0] value);
            trigger_t want;
            triggers_seen++;
            if (expected_triggers.size() == 0)
            begin
                $error("unexpected trigger: slot_index %0d trigger_value %0d", slot, value);
                mismatches++;
                return;
            end
            want = expected_triggers.pop_front();
            if (slot !== want.slot)
            begin
                $error("slot_index: expected %0d, actual %0d", want.slot, slot);
                mismatches++;
            end
            if (value !== want.value)
            begin
                $error("trigger_value: expected %0d, actual %0d", want.value, value);
                mismatches++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [7:0]                status_byte;
    logic [6:0]                controller_number;
    logic [6:0]                controller_value;
    logic                      out_valid;
    logic                      out_stall;
    logic [2:0]                slot_index;
    logic signed [VALUE_W-1:0] trigger_value;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [SLOT_W-1:0]         cfg_index;
    logic [CFG_W-1:0]          cfg_data;

    trigger_scoreboard sb = new();

    int idle_pct    = 0;
    int stall_pct   = 0;
    int words_sent  = 0;
    int slot_writes = 0;
    int cycle_count = 0;

    midi_cc_trigger_mapper DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .status_byte       (status_byte),
        .controller_number (controller_number),
        .controller_value  (controller_value),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .slot_index        (slot_index),
        .trigger_value     (trigger_value),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_midi_cc_trigger_mapper failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_pct > 0)
            out_stall <= ($urandom_range(99) < stall_pct);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(slot_index, trigger_value);
    end

    function automatic logic [CFG_W-1:0] make_slot(logic [6:0] ctrl, logic en, logic tog,
                                                   logic up, logic [15:0] span);
        slot_cfg_t c;
        c.ctrl    = ctrl;
        c.enable  = en;
        c.toggle  = tog;
        c.up_only = up;
        c.span    = span;
        return c;
    endfunction

    function automatic logic [CFG_W-1:0] random_slot();
        logic [15:0] span;
        logic [6:0]  ctrl;
        case ($urandom_range(5))
            0:       span = 16'h7FFF;
            1:       span = 16'h8000;
            2:       span = 16'h0000;
            3:       span = 16'h0001;
            4:       span = 16'hFFFF;
            default: span = 16'($urandom);
        endcase
        if ($urandom_range(99) < 80)
            ctrl = ($urandom_range(68) == 68) ? CTRL_EXTRA : 7'($urandom_range(67));
        else
            ctrl = 7'($urandom_range(127));
        return make_slot(ctrl, $urandom_range(9) != 0, $urandom_range(3) == 0,
                         $urandom_range(3) == 0, span);
    endfunction

    task automatic write_slot_reg(input int idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[SLOT_W-1:0];
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_slot(idx, data);
        slot_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic [7:0] st, input logic [6:0] cn, input logic [6:0] cv);
        if (idle_pct > 0)
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid          <= 1'b1;
        status_byte       <= st;
        controller_number <= cn;
        controller_value  <= cv;
        do @(posedge clk); while (in_stall);
        sb.note_word(st, cn, cv);
        words_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_triggers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0]       st;
        logic [6:0]       cn;
        logic [6:0]       cv;
        logic [CFG_W-1:0] data;
        int               r;

        rst_n             = 1'b0;
        in_valid          = 1'b0;
        status_byte       = '0;
        controller_number = '0;
        controller_value  = '0;
        out_stall         = 1'b0;
        cfg_valid         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // duplicate controller in slot 3, disabled slot 4, unhandled controller in slot 5,
        // toggle and up-only together in slot 6
        write_slot_reg(0, make_slot(7'd0,   1'b1, 1'b0, 1'b0, 16'h7FFF));
        write_slot_reg(1, make_slot(7'd67,  1'b1, 1'b0, 1'b1, 16'h8000));
        write_slot_reg(2, make_slot(7'd122, 1'b1, 1'b1, 1'b0, 16'd127));
        write_slot_reg(3, make_slot(7'd0,   1'b1, 1'b1, 1'b0, 16'd500));
        write_slot_reg(4, make_slot(7'd5,   1'b0, 1'b0, 1'b0, 16'd100));
        write_slot_reg(5, make_slot(7'd68,  1'b1, 1'b0, 1'b0, 16'd100));
        write_slot_reg(6, make_slot(7'd10,  1'b1, 1'b1, 1'b1, 16'd1000));
        write_slot_reg(7, make_slot(7'd20,  1'b1, 1'b0, 1'b1, 16'd1));

        send_word(8'h80, 7'd0,   7'd127);
        send_word(8'hAF, 7'd0,   7'd127);
        send_word(8'hC0, 7'd0,   7'd127);
        send_word(8'hFF, 7'd0,   7'd127);
        send_word(8'hB0, 7'd0,   7'd127);
        send_word(8'hBF, 7'd0,   7'd127);
        send_word(8'hB5, 7'd0,   7'd0);
        send_word(8'hB0, 7'd67,  7'd127);
        send_word(8'hB0, 7'd67,  7'd0);
        send_word(8'hB0, 7'd67,  7'd1);
        send_word(8'hB1, 7'd122, 7'd64);
        send_word(8'hB1, 7'd122, 7'd64);
        send_word(8'hB1, 7'd122, 7'd0);
        send_word(8'hB1, 7'd122, 7'd127);
        send_word(8'hB2, 7'd5,   7'd100);
        send_word(8'hB2, 7'd68,  7'd50);
        send_word(8'hB2, 7'd121, 7'd50);
        send_word(8'hB2, 7'd123, 7'd50);
        send_word(8'hB2, 7'd127, 7'd127);
        send_word(8'hB3, 7'd10,  7'd127);
        send_word(8'hB3, 7'd10,  7'd0);
        send_word(8'hB3, 7'd10,  7'd1);
        send_word(8'hB4, 7'd20,  7'd126);
        send_word(8'hB4, 7'd20,  7'd127);
        send_word(8'hB4, 7'd1,   7'd127);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 83; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 8;  stall_pct = 8;  end
            endcase
            for (int i = 0; i < SLOT_REGS; i++)
            begin
                data = random_slot();
                if (i > 0 && $urandom_range(4) == 0)
                    data[6:0] = sb.slot_cfg[i-1].ctrl;
                write_slot_reg(i, data);
            end
            repeat (WORDS_PER_PHASE)
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    st = CC_FIRST | 8'($urandom_range(15));
                    cn = sb.slot_cfg[$urandom_range(SLOT_REGS-1)].ctrl;
                end
                else if (r < 85)
                begin
                    st = CC_FIRST | 8'($urandom_range(15));
                    cn = 7'($urandom_range(127));
                end
                else
                begin
                    st = 8'($urandom_range(255));
                    cn = 7'($urandom_range(127));
                end
                case ($urandom_range(7))
                    0:       cv = 7'd0;
                    1:       cv = 7'd127;
                    default: cv = 7'($urandom_range(127));
                endcase
                send_word(st, cn, cv);
            end
            drain();
        end

        $display("Sent %0d MIDI words with %0d slot writes over four pacing phases;",
                 words_sent, slot_writes);
        $display("checked %0d triggers, %0d mismatches.", sb.triggers_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_triggers.size() == 0)
            $display("tb_midi_cc_trigger_mapper passed");
        else
            $display("tb_midi_cc_trigger_mapper failed");
        $finish;
    end

endmodule
